// ----- design/drbd_pkg.sv -----
// shared types, constants and helper functions of the delta run bitstream image decoder
package drbd_pkg;

  localparam int PixelCountBits = 24;
  localparam int ColorW         = 8;
  localparam int CountW         = 9;
  localparam int PalW           = 4;
  localparam int CfgCountW      = 25;
  localparam int CfgDataW       = 25;
  localparam int CfgIdxW        = 2;
  localparam int RemW           = (PixelCountBits + 1 > CfgCountW) ? PixelCountBits + 1
                                                                    : CfgCountW;
  localparam logic [RemW-1:0] PixLimit = RemW'(1) << PixelCountBits;

  localparam int GathW    = 4;
  localparam int BitIdxW  = 3;
  localparam int InDepth  = 2;
  localparam int InPtrW   = $clog2(InDepth);
  localparam int InCntW   = $clog2(InDepth + 1);
  localparam int OutDepth = 4;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  localparam logic [GathW-1:0]   DeltaBits    = GathW'(3);
  localparam logic [GathW-1:0]   RunBits      = GathW'(8);
  localparam logic [ColorW-1:0]  DeltaRunCode = ColorW'(4);
  localparam logic [ColorW-1:0]  DeltaBias    = ColorW'(4);
  localparam logic [CountW-1:0]  RunMax       = CountW'(256);
  localparam logic [PalW-1:0]    PalMax       = PalW'(8);
  localparam logic [BitIdxW-1:0] LastBitIdx   = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FILL         = 2'd0,
    CFG_PALETTE_BITS = 2'd1,
    CFG_PIXEL_COUNT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_PREFIX1,
    PH_PREFIX2,
    PH_LITERAL,
    PH_DELTA,
    PH_RUN
  } code_phase_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_START,
    BK_BITS,
    BK_END,
    BK_FLUSH
  } back_state_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [ColorW-1:0] color;
    logic [CountW-1:0] count;
    logic              done;
    logic              under;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [ColorW-1:0]    fill;
    logic [PalW-1:0]      palette_bits;
    logic [CfgCountW-1:0] pixel_count;
  } cfg_t;

  function automatic logic [PalW-1:0] lit_width(input logic [PalW-1:0] pb);
    logic [PalW-1:0] w;
    w = pb;
    if (pb == '0) w = PalW'(1);
    if (pb > PalMax) w = PalMax;
    return w;
  endfunction

  function automatic logic [RemW-1:0] target_pixels(input logic [CfgCountW-1:0] pc);
    logic [RemW-1:0] t;
    t = RemW'(pc);
    if (t == '0) t = RemW'(1);
    if (t > PixLimit) t = PixLimit;
    return t;
  endfunction

endpackage

// ----- design/delta_run_bitstream_image_decoder.sv -----
// top level of the delta run bitstream image decoder
// Decodes compressed palette images. Bytes enter through a queue port:
// a transaction happens when push is high and full is low; bits of a
// byte are read least significant first. first_byte_i starts an image
// and emits the fill pixel, last_byte_i ends its data.
// Results leave through a queue port: while empty is low the oldest
// result sits on the result ports, and pop takes it. Each result is a
// color with a repeat count of 1 to 256 pixels; a result with count 0
// and underrun_o set reports data that ended before the pixel count.
// last_result_o marks the final result caused by one input byte.
// The bit decoder takes a byte through a start step, at most one bit
// step for each of its bits, an end step and a close step; bits after
// a finished image are skipped. A queued byte is taken in the close
// step, an idle decoder takes it in its idle state. A result waits in a
// holding register until the next result or the close step moves it to
// the result queue; the last result of a byte moves there in the close
// step. A full result queue stalls the decoder; the two-entry input
// queue keeps taking bytes until it fills. Reset empties both queues,
// sets fill color 0, palette bits 8, pixel count 1 and ignores bytes
// until a first byte.
module delta_run_bitstream_image_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [drbd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    data_byte_i,
  input  logic                          first_byte_i,
  input  logic                          last_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [drbd_pkg::ColorW-1:0]   pixel_color_o,
  output logic [drbd_pkg::CountW-1:0]   repeat_count_o,
  output logic                          image_done_o,
  output logic                          underrun_o,
  output logic                          last_result_o
);
  import drbd_pkg::*;

  cfg_t       cfg_q;
  byte_item_t in_item, q_item;
  logic       q_valid, q_take;
  result_t    back_res, out_res;
  logic       back_push, out_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill         <= '0;
      cfg_q.palette_bits <= PalMax;
      cfg_q.pixel_count  <= CfgCountW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FILL:         cfg_q.fill         <= cfg_data_i[ColorW-1:0];
        CFG_PALETTE_BITS: cfg_q.palette_bits <= cfg_data_i[PalW-1:0];
        CFG_PIXEL_COUNT:  cfg_q.pixel_count  <= cfg_data_i[CfgCountW-1:0];
        default: ;
      endcase
    end
  end

  assign in_item.data  = data_byte_i;
  assign in_item.first = first_byte_i;
  assign in_item.last  = last_byte_i;

  drbd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (in_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .take_i  (q_take)
  );

  drbd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .item_take_o  (q_take),
    .res_push_o   (back_push),
    .res_o        (back_res),
    .res_full_i   (out_full)
  );

  drbd_out_q u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_push),
    .res_i   (back_res),
    .full_o  (out_full),
    .empty_o (empty),
    .res_o   (out_res),
    .pop_i   (pop)
  );

  assign pixel_color_o  = out_res.color;
  assign repeat_count_o = out_res.count;
  assign image_done_o   = out_res.done;
  assign underrun_o     = out_res.under;
  assign last_result_o  = out_res.last;

endmodule

// ----- design/drbd_front.sv -----
// input queue that takes compressed bytes and hands them to the bit decoder
module drbd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  drbd_pkg::byte_item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  output drbd_pkg::byte_item_t item_o,
  input  logic                 take_i
);
  import drbd_pkg::*;

  byte_item_t        mem_q [InDepth];
  logic [InPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [InCntW-1:0] cnt_q, cnt_d;
  logic              wr_en, rd_en;

  assign full_o  = (cnt_q == InCntW'(InDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = take_i && valid_o;

  always_comb begin
    wr_d  = wr_en ? wr_q + InPtrW'(1) : wr_q;
    rd_d  = rd_en ? rd_q + InPtrW'(1) : rd_q;
    cnt_d = cnt_q + InCntW'(wr_en) - InCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- design/drbd_out_q.sv -----
// result queue between the bit decoder and the result port
module drbd_out_q (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  drbd_pkg::result_t res_i,
  output logic              full_o,
  output logic              empty_o,
  output drbd_pkg::result_t res_o,
  input  logic              pop_i
);
  import drbd_pkg::*;

  result_t            mem_q [OutDepth];
  logic [OutPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [OutCntW-1:0] cnt_q, cnt_d;
  logic               wr_en, rd_en;

  assign full_o  = (cnt_q == OutCntW'(OutDepth));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rd_q];
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_en ? wr_q + OutPtrW'(1) : wr_q;
    rd_d  = rd_en ? rd_q + OutPtrW'(1) : rd_q;
    cnt_d = cnt_q + OutCntW'(wr_en) - OutCntW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= res_i;
    end
  end

endmodule

// ----- design/drbd_back.sv -----
// bit-serial code decoder that turns queued bytes into color and repeat results
module drbd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  drbd_pkg::cfg_t       cfg_i,
  input  logic                 item_valid_i,
  input  drbd_pkg::byte_item_t item_i,
  output logic                 item_take_o,
  output logic                 res_push_o,
  output drbd_pkg::result_t    res_o,
  input  logic                 res_full_i
);
  import drbd_pkg::*;

  back_state_e        state_q, state_d;
  logic [7:0]         byte_q;
  logic               first_q, last_q;
  logic [BitIdxW-1:0] idx_q;

  code_phase_e        phase_q, phase_d;
  logic [GathW-1:0]   gath_q, gath_d, gath_grown;
  logic [ColorW-1:0]  acc_q, acc_d, acc_grown;
  logic [ColorW-1:0]  color_q, color_d;
  logic [RemW-1:0]    remain_q, remain_d, rem_base;
  logic               fin_q, fin_d;

  result_t            pend_q, new_res;
  logic               pend_vld_q;

  logic               bit_cur, emit, under, new_vld, stall, done;
  logic [CountW-1:0]  emit_n, cnt;

  // code decode of one bit, fill pixel and underrun status
  always_comb begin
    bit_cur    = byte_q[idx_q];
    acc_grown  = acc_q | (ColorW'(bit_cur) << gath_q[BitIdxW-1:0]);
    gath_grown = gath_q + GathW'(1);
    phase_d    = phase_q;
    gath_d     = gath_q;
    acc_d      = acc_q;
    color_d    = color_q;
    rem_base   = remain_q;
    fin_d      = fin_q;
    emit       = 1'b0;
    emit_n     = CountW'(1);
    under      = 1'b0;
    unique case (state_q)
      BK_START: begin
        if (first_q) begin
          phase_d  = PH_PREFIX1;
          gath_d   = '0;
          acc_d    = '0;
          color_d  = cfg_i.fill;
          rem_base = target_pixels(cfg_i.pixel_count);
          fin_d    = 1'b0;
          emit     = 1'b1;
        end
      end
      BK_BITS: begin
        if (!fin_q) begin
          unique case (phase_q)
            PH_PREFIX1: begin
              if (bit_cur) phase_d = PH_PREFIX2;
              else emit = 1'b1;
            end
            PH_PREFIX2: begin
              gath_d  = '0;
              acc_d   = '0;
              phase_d = bit_cur ? PH_DELTA : PH_LITERAL;
            end
            PH_LITERAL: begin
              gath_d = gath_grown;
              acc_d  = acc_grown;
              if (gath_grown >= lit_width(cfg_i.palette_bits)) begin
                color_d = acc_grown;
                phase_d = PH_PREFIX1;
                emit    = 1'b1;
              end
            end
            PH_DELTA: begin
              gath_d = gath_grown;
              acc_d  = acc_grown;
              if (gath_grown >= DeltaBits) begin
                if (acc_grown != DeltaRunCode) begin
                  color_d = color_q + acc_grown - DeltaBias;
                  phase_d = PH_PREFIX1;
                  emit    = 1'b1;
                end else begin
                  gath_d  = '0;
                  acc_d   = '0;
                  phase_d = PH_RUN;
                end
              end
            end
            PH_RUN: begin
              gath_d = gath_grown;
              acc_d  = acc_grown;
              if (gath_grown >= RunBits) begin
                emit_n  = (acc_grown == '0) ? RunMax : CountW'(acc_grown);
                phase_d = PH_PREFIX1;
                emit    = 1'b1;
              end
            end
            default: phase_d = PH_PREFIX1;
          endcase
        end
      end
      BK_END: begin
        if (last_q && !fin_q) begin
          under   = 1'b1;
          fin_d   = 1'b1;
          phase_d = PH_PREFIX1;
          gath_d  = '0;
          acc_d   = '0;
        end
      end
      default: ;
    endcase

    // run length cut to the pixels still missing
    done     = (rem_base <= RemW'(emit_n));
    cnt      = done ? rem_base[CountW-1:0] : emit_n;
    remain_d = emit ? rem_base - RemW'(cnt) : rem_base;
    if (emit && done) fin_d = 1'b1;

    new_res.color = under ? '0 : color_d;
    new_res.count = under ? '0 : cnt;
    new_res.done  = under ? 1'b0 : done;
    new_res.under = under;
    new_res.last  = 1'b0;
    new_vld       = emit || under;

    stall      = pend_vld_q && res_full_i && (new_vld || state_q == BK_FLUSH);
    res_push_o = pend_vld_q && !res_full_i && (new_vld || state_q == BK_FLUSH);
    res_o      = pend_q;
    res_o.last = (state_q == BK_FLUSH);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (item_valid_i) state_d = BK_START;
      BK_START: if (!stall) state_d = BK_BITS;
      BK_BITS:  if (!stall && (fin_q || idx_q == LastBitIdx)) state_d = BK_END;
      BK_END:   if (!stall) state_d = BK_FLUSH;
      BK_FLUSH: if (!stall) state_d = item_valid_i ? BK_START : BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  assign item_take_o = item_valid_i &&
                       (state_q == BK_IDLE || (state_q == BK_FLUSH && !stall));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      idx_q      <= '0;
      first_q    <= 1'b0;
      last_q     <= 1'b0;
      phase_q    <= PH_PREFIX1;
      gath_q     <= '0;
      acc_q      <= '0;
      color_q    <= '0;
      remain_q   <= '0;
      fin_q      <= 1'b1;
      pend_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (item_take_o) begin
        first_q <= item_i.first;
        last_q  <= item_i.last;
        idx_q   <= '0;
      end else if (state_q == BK_BITS && !stall) begin
        idx_q <= idx_q + BitIdxW'(1);
      end
      if (!stall) begin
        phase_q  <= phase_d;
        gath_q   <= gath_d;
        acc_q    <= acc_d;
        color_q  <= color_d;
        remain_q <= remain_d;
        fin_q    <= fin_d;
        if (new_vld) begin
          pend_vld_q <= 1'b1;
        end else if (state_q == BK_FLUSH) begin
          pend_vld_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      byte_q <= item_i.data;
    end
    if (!stall && new_vld) begin
      pend_q <= new_res;
    end
  end

  a_push_has_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> pend_vld_q)
    else $error("result pushed without a pending result");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(state_q) && $stable(pend_vld_q) && $stable(remain_q))
    else $error("decoder state moved while stalled");

  a_no_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (res_o.count != '0 || res_o.under))
    else $error("zero length pixel result");

  a_finished_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_BITS && fin_q && !stall) |=> state_q == BK_END)
    else $error("bits decoded after image finished");

endmodule

// ----- bench/drbd_checker.sv -----
// checker that decodes every accepted byte alongside the decoder and compares the pixel runs
`timescale 1ns / 1ps
module drbd_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [drbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [drbd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          push,
  input  logic                          full,
  input  logic [7:0]                    data_byte_i,
  input  logic                          first_byte_i,
  input  logic                          last_byte_i,
  input  logic                          empty,
  input  logic                          pop,
  input  logic [drbd_pkg::ColorW-1:0]   pixel_color_i,
  input  logic [drbd_pkg::CountW-1:0]   repeat_count_i,
  input  logic                          image_done_i,
  input  logic                          underrun_i,
  input  logic                          last_result_i,
  output int                            errors_o,
  output int                            pending_o
);
  import drbd_pkg::*;

  logic [7:0]  fill_q;
  logic [3:0]  pal_q;
  logic [24:0] pcount_q;

  code_phase_e phase;
  logic [3:0]  ngath;
  logic [7:0]  acc;
  logic [7:0]  color;
  logic [25:0] emitted;
  logic        finished;

  result_t     byte_runs[$];
  result_t     pixel_runs_q[$];

  function automatic logic [25:0] pixel_target();
    logic [25:0] t;
    t = {1'b0, pcount_q};
    if (t == '0) t = 26'd1;
    if (t > (26'd1 << PixelCountBits)) t = 26'd1 << PixelCountBits;
    return t;
  endfunction

  function automatic logic [3:0] literal_bits();
    logic [3:0] w;
    w = pal_q;
    if (pal_q == '0) w = 4'd1;
    if (pal_q > PalMax) w = PalMax;
    return w;
  endfunction

  function automatic void add_run(input logic [8:0] n);
    logic [25:0] tgt;
    logic [25:0] left;
    logic [8:0]  cnt;
    result_t     r;
    tgt = pixel_target();
    left = (tgt > emitted) ? tgt - emitted : '0;
    cnt = ({17'd0, n} < left) ? n : left[8:0];
    emitted = emitted + 26'(cnt);
    if (emitted >= tgt) finished = 1'b1;
    r = '0;
    r.color = color;
    r.count = cnt;
    r.done = finished;
    byte_runs.insert(byte_runs.size(), r);
  endfunction

  function automatic void gather(input logic b);
    acc = acc | (8'(b) << ngath[2:0]);
    ngath = ngath + 4'd1;
  endfunction

  function automatic void take_bit(input logic b);
    case (phase)
      PH_PREFIX1: begin
        if (b) phase = PH_PREFIX2;
        else add_run(9'd1);
      end
      PH_PREFIX2: begin
        ngath = '0;
        acc = '0;
        if (b) phase = PH_DELTA;
        else phase = PH_LITERAL;
      end
      PH_LITERAL: begin
        gather(b);
        if (ngath >= literal_bits()) begin
          color = acc;
          phase = PH_PREFIX1;
          add_run(9'd1);
        end
      end
      PH_DELTA: begin
        gather(b);
        if (ngath >= DeltaBits) begin
          if (acc != DeltaRunCode) begin
            color = color + acc - DeltaBias;
            phase = PH_PREFIX1;
            add_run(9'd1);
          end else begin
            ngath = '0;
            acc = '0;
            phase = PH_RUN;
          end
        end
      end
      default: begin
        gather(b);
        if (ngath >= RunBits) begin
          phase = PH_PREFIX1;
          add_run((acc == '0) ? RunMax : {1'b0, acc});
        end
      end
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] data, input logic first,
                                      input logic last);
    int      i;
    result_t r;
    byte_runs.delete();
    if (first) begin
      phase = PH_PREFIX1;
      ngath = '0;
      acc = '0;
      color = fill_q;
      emitted = '0;
      finished = 1'b0;
      add_run(9'd1);
    end
    for (i = 0; i < 8; i++) begin
      if (!finished) take_bit(data[i]);
    end
    if (last && !finished) begin
      r = '0;
      r.under = 1'b1;
      byte_runs.insert(byte_runs.size(), r);
      finished = 1'b1;
      phase = PH_PREFIX1;
      ngath = '0;
      acc = '0;
    end
    if (byte_runs.size() > 0) begin
      r = byte_runs.pop_back();
      r.last = 1'b1;
      byte_runs.insert(byte_runs.size(), r);
    end
    while (byte_runs.size() > 0)
      pixel_runs_q.insert(pixel_runs_q.size(), byte_runs.pop_front());
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      fill_q = '0;
      pal_q = 4'd8;
      pcount_q = 25'd1;
      phase = PH_PREFIX1;
      ngath = '0;
      acc = '0;
      color = '0;
      emitted = '0;
      finished = 1'b1;
      pixel_runs_q.delete();
      errors_o = 0;
      pending_o = 0;
    end else begin
      if (pop && !empty) begin
        got.color = pixel_color_i;
        got.count = repeat_count_i;
        got.done = image_done_i;
        got.under = underrun_i;
        got.last = last_result_i;
        if (pixel_runs_q.size() == 0) begin
          if (errors_o < 10)
            $display("%0t: unexpected transaction color=%0d count=%0d done=%0b under=%0b last=%0b",
                     $realtime, got.color, got.count, got.done, got.under, got.last);
          errors_o = errors_o + 1;
        end else begin
          want = pixel_runs_q.pop_front();
          if (got.color != want.color || got.count != want.count || got.done != want.done ||
              got.under != want.under || got.last != want.last) begin
            if (errors_o < 10)
              $display("%0t: mismatch exp color=%0d count=%0d done=%0b under=%0b last=%0b %s",
                       $realtime, want.color, want.count, want.done, want.under, want.last,
                       $sformatf("got color=%0d count=%0d done=%0b under=%0b last=%0b",
                                 got.color, got.count, got.done, got.under, got.last));
            errors_o = errors_o + 1;
          end
        end
      end
      if (push && !full) decode_byte(data_byte_i, first_byte_i, last_byte_i);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_FILL:         fill_q = cfg_data_i[7:0];
          CFG_PALETTE_BITS: pal_q = cfg_data_i[3:0];
          CFG_PIXEL_COUNT:  pcount_q = cfg_data_i[24:0];
          default: ;
        endcase
      end
      pending_o = pixel_runs_q.size();
    end
  end

endmodule

// ----- bench/delta_run_bitstream_image_decoder_tb.sv -----
// testbench top: drives compressed images through the decoder and reports the verdict
`timescale 1ns / 1ps
module delta_run_bitstream_image_decoder_tb;
  import drbd_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                push;
  logic                full;
  logic [7:0]          data_byte_i;
  logic                first_byte_i;
  logic                last_byte_i;
  logic                empty;
  logic                pop;
  logic [ColorW-1:0]   pixel_color_o;
  logic [CountW-1:0]   repeat_count_o;
  logic                image_done_o;
  logic                underrun_o;
  logic                last_result_o;
  int                  errors;
  int                  pending;

  int   tx_idle_pct;
  int   rx_stall_pct;
  logic hold_req;
  logic hold_ack;
  int   lit_bits;
  int   bytes_sent;
  logic code_bits[$];

  delta_run_bitstream_image_decoder uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .data_byte_i, .first_byte_i, .last_byte_i,
    .empty, .pop, .pixel_color_o, .repeat_count_o, .image_done_o,
    .underrun_o, .last_result_o
  );

  drbd_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .push, .full, .data_byte_i, .first_byte_i, .last_byte_i,
    .empty, .pop,
    .pixel_color_i  (pixel_color_o),
    .repeat_count_i (repeat_count_o),
    .image_done_i   (image_done_o),
    .underrun_i     (underrun_o),
    .last_result_i  (last_result_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver side
  initial begin
    int k;
    pop = 1'b0;
    hold_ack = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        pop <= 1'b0;
        for (k = 0; k < 300; k++) @(posedge clk_i);
        hold_ack = hold_req;
      end
      pop <= (rx_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 62; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 62; end
      default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
    endcase
  endtask

  task automatic write_config(input logic [7:0] fill, input logic [3:0] pal,
                              input logic [24:0] count);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_FILL;
    cfg_data_i <= CfgDataW'(fill);
    @(posedge clk_i);
    cfg_idx_i <= CFG_PALETTE_BITS;
    cfg_data_i <= CfgDataW'(pal);
    @(posedge clk_i);
    cfg_idx_i <= CFG_PIXEL_COUNT;
    cfg_data_i <= CfgDataW'(count);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lit_bits = (pal == 0) ? 1 : (pal > 8) ? 8 : pal;
  endtask

  task automatic send_raw(input logic [7:0] data, input logic first, input logic last);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    data_byte_i <= data;
    first_byte_i <= first;
    last_byte_i <= last;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // stops offering, waits for every expected run, then lets queued bytes finish
  task automatic settle();
    push <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic void put_bits(input logic [7:0] v, input int n);
    int i;
    for (i = 0; i < n; i++) code_bits.insert(code_bits.size(), v[i]);
  endfunction

  function automatic void put_literal(input logic [7:0] c);
    put_bits(8'b01, 2);
    put_bits(c, lit_bits);
  endfunction

  function automatic void put_delta(input logic [2:0] v);
    put_bits(8'b11, 2);
    put_bits(8'(v), 3);
  endfunction

  function automatic void put_run(input logic [7:0] n);
    put_delta(DeltaRunCode[2:0]);
    put_bits(n, 8);
  endfunction

  function automatic void put_random_code();
    int k;
    int v;
    k = $urandom_range(99);
    if (k < 30) begin
      put_bits(8'b0, 1);
    end else if (k < 55) begin
      put_literal(8'($urandom_range(255)));
    end else if (k < 85) begin
      v = $urandom_range(6);
      if (v >= 4) v++;
      put_delta(3'(v));
    end else begin
      put_run(($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(255)));
    end
  endfunction

  task automatic send_image(input logic mark_last);
    int   i;
    logic first;
    logic [7:0] data;
    while (code_bits.size() == 0 || code_bits.size() % 8 != 0)
      code_bits.insert(code_bits.size(), 1'($urandom_range(1)));
    first = 1'b1;
    while (code_bits.size() > 0) begin
      for (i = 0; i < 8; i++) data[i] = code_bits.pop_front();
      send_raw(data, first, mark_last && code_bits.size() == 0);
      first = 1'b0;
    end
  endtask

  initial begin
    int phase_no;
    int goal;
    int k;
    int n;
    logic [3:0]  pal;
    logic [24:0] count;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_FILL;
    cfg_data_i = '0;
    push = 1'b0;
    data_byte_i = '0;
    first_byte_i = 1'b0;
    last_byte_i = 1'b0;
    hold_req = 1'b0;
    bytes_sent = 0;
    lit_bits = 8;
    set_idling(0);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: fill pixel alone ends the image, later bytes are ignored
    send_raw(8'hFF, 1'b1, 1'b0);
    send_raw(8'h00, 1'b0, 1'b1);
    settle();

    // every code kind, color wrap, longest runs and a truncated run
    write_config(8'hFF, 4'd8, 25'd600);
    put_bits(8'b0, 1);
    put_literal(8'hFF);
    put_literal(8'h00);
    put_delta(3'd0);
    put_delta(3'd7);
    put_delta(3'd3);
    put_run(8'd0);
    put_run(8'd255);
    put_run(8'd1);
    put_run(8'd0);
    put_bits(8'b0, 1);
    send_image(1'b1);
    settle();

    // one-bit palette, saturated pixel count, underrun and restart
    write_config(8'h3C, 4'd0, 25'h1FFFFFF);
    put_literal(8'h01);
    put_literal(8'h00);
    put_delta(3'd7);
    put_run(8'd5);
    send_image(1'b1);
    put_bits(8'b11, 2);
    send_image(1'b0);
    put_literal(8'h01);
    send_image(1'b0);
    send_raw(8'($urandom_range(255)), 1'b0, 1'b1);
    settle();

    // oversized palette width and zero pixel count
    write_config(8'h81, 4'd15, 25'd0);
    send_raw(8'h00, 1'b1, 1'b1);
    send_raw(8'hAA, 1'b1, 1'b0);
    settle();

    for (phase_no = 0; phase_no < 8; phase_no++) begin
      k = $urandom_range(99);
      pal = (k < 80) ? 4'($urandom_range(8, 1)) : 4'($urandom_range(15));
      k = $urandom_range(99);
      if (k < 60) count = 25'($urandom_range(40, 1));
      else if (k < 85) count = 25'($urandom_range(400, 41));
      else if (k < 95) count = 25'($urandom_range(3, 1));
      else count = 25'($urandom_range(32'h1FFFFFF));
      write_config(8'($urandom_range(255)), pal, count);
      set_idling(phase_no % 4);
      if (phase_no == 4) hold_req = 1'b1;
      goal = bytes_sent + 48;
      while (bytes_sent < goal) begin
        k = $urandom_range(99);
        if (k < 85) begin
          n = $urandom_range(14, 1);
          repeat (n) put_random_code();
          send_image($urandom_range(99) < 85);
          if (k >= 75) send_raw(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end else begin
          repeat ($urandom_range(4, 1))
            send_raw(8'($urandom_range(255)), $urandom_range(99) < 30,
                     $urandom_range(99) < 30);
        end
      end
      send_raw(8'($urandom_range(255)), 1'b0, 1'b1);
      settle();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- delta_run_bitstream_image_decoder.f -----
design/drbd_pkg.sv
design/drbd_front.sv
design/drbd_out_q.sv
design/drbd_back.sv
design/delta_run_bitstream_image_decoder.sv
bench/drbd_checker.sv
bench/delta_run_bitstream_image_decoder_tb.sv
